// ----- hw/rtl/tbn_pkg.sv -----
// Package of shared types, byte constants and normalizing functions for the text byte normalizer.
`timescale 1ns / 1ps

package tbn_pkg;

	// Most result items that one input item can cause, and the widths that follow.
	localparam int MaxResults = 4;
	localparam int CountW     = $clog2(MaxResults + 1);
	localparam int IdxW       = $clog2(MaxResults);

	typedef logic [7:0] byte_t;

	// Curly-quote sequence bytes.
	localparam byte_t BYTE_LEAD   = 8'hE2;
	localparam byte_t BYTE_MID    = 8'h80;
	localparam byte_t BYTE_LSQUO  = 8'h98;
	localparam byte_t BYTE_RSQUO  = 8'h99;
	localparam byte_t BYTE_LDQUO  = 8'h9C;
	localparam byte_t BYTE_RDQUO  = 8'h9D;

	// Punctuation that is dropped.
	localparam byte_t BYTE_PERIOD = 8'h2E;
	localparam byte_t BYTE_COMMA  = 8'h2C;
	localparam byte_t BYTE_EXCL   = 8'h21;
	localparam byte_t BYTE_QUEST  = 8'h3F;
	localparam byte_t BYTE_DQUOTE = 8'h22;
	localparam byte_t BYTE_SQUOTE = 8'h27;

	// Whitespace bytes.
	localparam byte_t BYTE_SPACE  = 8'h20;
	localparam byte_t BYTE_TAB    = 8'h09;
	localparam byte_t BYTE_LF     = 8'h0A;
	localparam byte_t BYTE_VT     = 8'h0B;
	localparam byte_t BYTE_FF     = 8'h0C;
	localparam byte_t BYTE_CR     = 8'h0D;

	// Case folding.
	localparam byte_t BYTE_UPPER_A = 8'h41;
	localparam byte_t BYTE_UPPER_Z = 8'h5A;
	localparam byte_t CASE_OFFSET  = 8'h20;

	// Number of curly-quote prefix bytes held back.
	typedef logic [1:0] held_t;
	localparam held_t HELD_NONE  = 2'd0;
	localparam held_t HELD_LEAD  = 2'd1;
	localparam held_t HELD_MID   = 2'd2;

	// Result list built up while one item is handled, with the spacing state it leaves.
	typedef struct packed {
		logic                         pend;
		logic                         seen;
		logic [CountW-1:0]            n;
		logic [MaxResults-1:0][7:0]   bytes;
	} emit_t;

	function automatic logic is_space(byte_t b);
		return (b == BYTE_SPACE) || (b == BYTE_TAB) || (b == BYTE_LF) ||
			(b == BYTE_CR) || (b == BYTE_FF) || (b == BYTE_VT);
	endfunction

	function automatic logic is_drop(byte_t b);
		return (b == BYTE_PERIOD) || (b == BYTE_COMMA) || (b == BYTE_EXCL) ||
			(b == BYTE_QUEST) || (b == BYTE_DQUOTE) || (b == BYTE_SQUOTE);
	endfunction

	function automatic logic is_curly_tail(byte_t b);
		return (b == BYTE_LSQUO) || (b == BYTE_RSQUO) || (b == BYTE_LDQUO) ||
			(b == BYTE_RDQUO);
	endfunction

	// Appends one byte to the result list.
	function automatic emit_t put_byte(emit_t e, byte_t b);
		emit_t r;
		r = e;
		if (r.n < CountW'(MaxResults)) begin
			r.bytes[r.n[IdxW-1:0]] = b;
			r.n = r.n + CountW'(1);
		end
		return r;
	endfunction

	// Handles one byte that is not part of a curly-quote sequence.
	function automatic emit_t plain_byte(emit_t e, byte_t b);
		emit_t r;
		byte_t lc;
		r  = e;
		lc = ((b >= BYTE_UPPER_A) && (b <= BYTE_UPPER_Z)) ? (b + CASE_OFFSET) : b;
		if (is_drop(b)) begin
			return r;
		end
		if (is_space(b)) begin
			if (r.seen) begin
				r.pend = 1'b1;
			end
			return r;
		end
		if (r.pend) begin
			r      = put_byte(r, BYTE_SPACE);
			r.pend = 1'b0;
		end
		r      = put_byte(r, lc);
		r.seen = 1'b1;
		return r;
	endfunction

endpackage

// ----- hw/rtl/tbn_in_if.sv -----
// Input channel interface: one raw text byte and its last-of-text flag per item.
`timescale 1ns / 1ps

interface tbn_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_of_text;

	modport source (output valid, output in_byte, output last_of_text, input ready);
	modport sink   (input valid, input in_byte, input last_of_text, output ready);
endinterface

// ----- hw/rtl/tbn_out_if.sv -----
// Output channel interface: one normalized byte or end marker per item.
`timescale 1ns / 1ps

interface tbn_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_present;
	logic       end_of_text;

	modport source (output valid, output out_byte, output byte_present, output end_of_text,
		input ready);
	modport sink   (input valid, input out_byte, input byte_present, input end_of_text,
		output ready);
endinterface

// ----- hw/rtl/text_byte_normalizer_top.sv -----
// Top level of the text byte normalizer: input register, normalizing logic and result buffer.
//
//  Channel   | Direction | Payload                                  | Handshake
//  ----------+-----------+------------------------------------------+-------------
//  text_in   | in        | in_byte[7:0], last_of_text               | valid/ready
//  text_out  | out       | out_byte[7:0], byte_present, end_of_text | valid/ready
//
// An accepted item is held in the input register, normalized there and its results (zero
// to four) are loaded into the result buffer, which drains one per cycle while text_out is
// ready. Items that cause at most one result flow at one item per cycle while text_out is
// ready; an item that causes more holds the buffer until its results drain, and the input
// stalls meanwhile. Reset clears the pipeline valid flags and the spacing and prefix state;
// no clearing pass is needed.
`timescale 1ns / 1ps

module text_byte_normalizer_top (
	input  logic     clk,
	input  logic     arst_n,
	tbn_in_if.sink   text_in,
	tbn_out_if.source text_out
);
	import tbn_pkg::*;

	// Input register.
	logic  valid_s1;
	byte_t byte_s1;
	logic  last_s1;

	// Result buffer.
	logic [MaxResults-1:0][7:0] bytes_s2;
	logic [CountW-1:0]          rem_s2;
	logic [IdxW-1:0]            idx_s2;
	logic                       marker_s2;
	logic                       end_s2;

	// Text state.
	held_t held_q;
	logic  pend_q;
	logic  seen_q;

	// Handshake and next-state logic.
	logic              s2_free;
	logic              s1_move;
	logic              in_take;
	logic              out_take;
	emit_t             step_emit;
	emit_t             fin_emit;
	held_t             step_held;
	logic              step_marker;
	logic [CountW-1:0] step_count;

	assign out_take = text_out.valid && text_out.ready;
	assign s2_free  = (rem_s2 == '0) || ((rem_s2 == CountW'(1)) && text_out.ready);
	assign s1_move  = valid_s1 && s2_free;
	assign text_in.ready = !valid_s1 || s2_free;
	assign in_take  = text_in.valid && text_in.ready;

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (text_in.ready) begin
			valid_s1 <= text_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			byte_s1 <= text_in.in_byte;
			last_s1 <= text_in.last_of_text;
		end
	end

	// Normalize the held item: resolve the prefix, then handle the byte afresh if needed.
	always_comb begin
		step_emit      = '0;
		step_emit.pend = pend_q;
		step_emit.seen = seen_q;
		step_held      = HELD_NONE;
		case (held_q)
			HELD_LEAD: begin
				if (byte_s1 == BYTE_MID) begin
					step_held = HELD_MID;
				end else begin
					step_emit = plain_byte(step_emit, BYTE_LEAD);
					if (byte_s1 == BYTE_LEAD) begin
						step_held = HELD_LEAD;
					end else begin
						step_emit = plain_byte(step_emit, byte_s1);
					end
				end
			end
			HELD_MID: begin
				if (!is_curly_tail(byte_s1)) begin
					step_emit = plain_byte(step_emit, BYTE_LEAD);
					step_emit = plain_byte(step_emit, BYTE_MID);
					if (byte_s1 == BYTE_LEAD) begin
						step_held = HELD_LEAD;
					end else begin
						step_emit = plain_byte(step_emit, byte_s1);
					end
				end
			end
			default: begin
				if (byte_s1 == BYTE_LEAD) begin
					step_held = HELD_LEAD;
				end else begin
					step_emit = plain_byte(step_emit, byte_s1);
				end
			end
		endcase
	end

	// On the last byte, flush held prefix bytes and add an end marker if nothing came out.
	always_comb begin
		fin_emit = step_emit;
		if (last_s1) begin
			if ((step_held == HELD_LEAD) || (step_held == HELD_MID)) begin
				fin_emit = plain_byte(fin_emit, BYTE_LEAD);
			end
			if (step_held == HELD_MID) begin
				fin_emit = plain_byte(fin_emit, BYTE_MID);
			end
		end
		step_marker = last_s1 && (fin_emit.n == '0);
		step_count  = step_marker ? CountW'(1) : fin_emit.n;
	end

	// Text state advances when the held item moves into the result buffer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= HELD_NONE;
			pend_q <= 1'b0;
			seen_q <= 1'b0;
		end else if (s1_move) begin
			if (last_s1) begin
				held_q <= HELD_NONE;
				pend_q <= 1'b0;
				seen_q <= 1'b0;
			end else begin
				held_q <= step_held;
				pend_q <= fin_emit.pend;
				seen_q <= fin_emit.seen;
			end
		end
	end

	// Result buffer: loaded with the whole list, drained one item per handshake.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_s2    <= '0;
			idx_s2    <= '0;
			marker_s2 <= 1'b0;
			end_s2    <= 1'b0;
		end else if (s2_free) begin
			rem_s2    <= s1_move ? step_count : '0;
			idx_s2    <= '0;
			marker_s2 <= s1_move && step_marker;
			end_s2    <= s1_move && last_s1;
		end else if (out_take) begin
			rem_s2 <= rem_s2 - CountW'(1);
			idx_s2 <= idx_s2 + IdxW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			bytes_s2 <= fin_emit.bytes;
		end
	end

	// Output drive.
	assign text_out.valid        = (rem_s2 != '0);
	assign text_out.out_byte     = marker_s2 ? '0 : bytes_s2[idx_s2];
	assign text_out.byte_present = !marker_s2;
	assign text_out.end_of_text  = end_s2 && (rem_s2 == CountW'(1));

	// The buffer never holds more results than one item can cause.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rem_s2 <= CountW'(MaxResults))
		else $error("result buffer count out of range");

	// An empty end marker is always the final result of a text.
	a_marker_end: assert property (@(posedge clk) disable iff (!arst_n)
		(text_out.valid && !text_out.byte_present) |-> text_out.end_of_text)
		else $error("end marker without end of text");

	// A last byte leaves the text state back at its reset values.
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_move && last_s1) |=> (held_q == HELD_NONE) && !pend_q && !seen_q)
		else $error("text state not cleared after last byte");

	// A space can only be pending once some byte has been emitted.
	a_pend_seen: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> seen_q)
		else $error("pending space before any emitted byte");

endmodule
